// ----- rtl/cpts_pkg.sv -----
// Package for the counter priority task scheduler: sizes, command codes, cell types.
// No dependencies.
package cpts_pkg;
   localparam int SLOTS = 16;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS) + 1;
   localparam int TIME_W = 9;
   localparam int PRIO_W = 8;
   localparam int DEPTH_W = 8;

   localparam logic [2:0] CMD_TICK = 3'd0;
   localparam logic [2:0] CMD_YIELD = 3'd1;
   localparam logic [2:0] CMD_CREATE = 3'd2;
   localparam logic [2:0] CMD_EXIT = 3'd3;
   localparam logic [2:0] CMD_PDIS = 3'd4;
   localparam logic [2:0] CMD_PEN = 3'd5;

   typedef struct packed {
      logic [2:0] cmd;
      logic [PRIO_W-1:0] new_priority;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] current_task;
      logic switched;
      logic status;
      logic [SLOT_W-1:0] new_task;
   } rsp_type;

   // Action a cell applies when its contents sit at the head of the ring.
   typedef enum logic [2:0] {
      OP_NONE, OP_DEC, OP_ZERO, OP_KILL, OP_PUP, OP_PDN, OP_FILL, OP_AGE
   } op_type;

   typedef struct packed {
      logic used;
      logic running;
      logic [TIME_W-1:0] time_left;
      logic [PRIO_W-1:0] prio;
      logic [DEPTH_W-1:0] depth;
   } slot_type;
endpackage

// ----- rtl/cpts_if.sv -----
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload type given by the instantiating module.
interface cpts_if #(parameter type T = logic) (input logic clock);
   logic valid;
   logic ready;
   T payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/counter_priority_task_scheduler.sv -----
// Top level of the counter priority task scheduler.
// Depends on cpts_pkg, cpts_if, cpts_cell and cpts_head.
//
// The slot table is a ring of 16 cells that rotates one place per cycle
// during the clearing pass and the command, pick and age turns, and holds
// otherwise; the slot in cell 0 passes through the head stage, which updates
// it and feeds the best-pick comparator. After reset a clearing pass loads the
// reset image into the ring; req ready stays low during it. One item takes an
// accept in the idle state, one full turn that applies the command, one more
// turn for the pick scan when the command reschedules, one more turn for aging
// plus re-scan when every running counter is zero, and the done state that
// loads the result register. One item is in work at a time; the result waits
// in its output register while the next item may be taken, and that next item
// holds before its result load until the previous result has left. A csr write
// (idle only) loads slot 0 priority and counter straight into cell 0, which
// holds slot 0 when idle since rotations are always whole turns; a write
// during the clearing pass restarts the pass with the new value.
module counter_priority_task_scheduler (
   input  logic clock,
   input  logic reset,
   cpts_if.sink req,
   cpts_if.source rsp,
   input  logic csr_we,
   input  logic [cpts_pkg::PRIO_W-1:0] csr_wdata
);
   import cpts_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_CMD, S_PICK, S_AGE, S_DONE} state_type;
   state_type state_ff;
   slot_type cells [SLOTS];
   slot_type head_out, cell0_in, init_slot;
   slot_type tail_ff;
   op_type op;
   logic [SLOT_W-1:0] pos_ff, cur_ff, best_ff, before_ff, run_ff;
   logic [TIME_W-1:0] bestv_ff;
   logic found_ff, resched_ff, status_ff;
   logic [CNT_W-1:0] taken_ff;
   logic [SLOT_W-1:0] newt_ff;
   logic [2:0] cmd_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic rot, rot_all, rsp_valid_ff, init_ff;
   rsp_type rsp_ff;
   logic last, better, accept, csr_load, rsp_load;
   logic reached_zero, resched_set;
   logic [SLOT_W-1:0] pick;
   logic pick_found;

   assign last = (pos_ff == SLOT_W'(SLOTS-1));
   assign rot = (state_ff == S_CMD) || (state_ff == S_PICK) || (state_ff == S_AGE);
   assign rot_all = rot || init_ff;

   always_comb begin
      op = OP_NONE;
      if (state_ff == S_CMD) begin
         if (pos_ff == cur_ff) begin
            case (cmd_ff)
               CMD_TICK: op = OP_DEC;
               CMD_YIELD: op = OP_ZERO;
               CMD_EXIT: op = OP_KILL;
               CMD_PDIS: op = OP_PUP;
               CMD_PEN: op = OP_PDN;
               default: op = OP_NONE;
            endcase
         end
         if (cmd_ff == CMD_CREATE && taken_ff < CNT_W'(SLOTS) && pos_ff == taken_ff[SLOT_W-1:0])
            op = OP_FILL;
      end else if (state_ff == S_AGE) begin
         op = OP_AGE;
      end
   end

   cpts_head u_head (.op(op), .slot_in(cells[0]), .prio(prio_ff), .slot_out(head_out));

   // csr load of slot 0 happens in place; ring is aligned while idle.
   assign csr_load = csr_we && (state_ff == S_IDLE) && !init_ff;
   always_comb begin
      cell0_in = cells[1];
      if (csr_load) begin
         cell0_in = cells[0];
         cell0_in.prio = csr_wdata;
         cell0_in.time_left = TIME_W'(csr_wdata);
      end
   end

   cpts_cell u_cell0 (.clock(clock), .load(rot_all || csr_load), .prev(cell0_in),
                      .slot_ff(cells[0]));

   genvar g;
   generate
      for (g = 1; g < SLOTS - 1; g++) begin : g_ring
         cpts_cell u_cell (.clock(clock), .load(rot_all), .prev(cells[g+1]),
                           .slot_ff(cells[g]));
      end
   endgenerate

   // Last cell takes the head output, or the reset image during the clearing pass.
   assign cells[SLOTS-1] = tail_ff;

   always_comb begin
      init_slot = '0;
      if (pos_ff == '0) begin
         init_slot.used = 1'b1;
         init_slot.running = 1'b1;
         init_slot.prio = prio_ff;
         init_slot.time_left = TIME_W'(prio_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rot_all) begin
         tail_ff <= init_ff ? init_slot : head_out;
      end
   end

   // Best-pick comparator: first strictly larger counter wins, so lowest slot on ties.
   assign better = head_out.used && head_out.running &&
                   (!found_ff || head_out.time_left > bestv_ff);

   always_comb begin
      pick = better ? pos_ff : best_ff;
      pick_found = found_ff || better;
   end

   assign reached_zero = (head_out.time_left == '0) && (head_out.depth == '0);
   assign resched_set = (state_ff == S_CMD) && (pos_ff == cur_ff) &&
                        (cmd_ff == CMD_YIELD || cmd_ff == CMD_EXIT ||
                         (cmd_ff == CMD_TICK && reached_zero));

   assign req.ready = (state_ff == S_IDLE) && !init_ff && !csr_we;
   assign accept = req.valid && req.ready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         init_ff <= 1'b1;
         pos_ff <= '0;
         prio_ff <= PRIO_W'(15);
         run_ff <= '0;
         taken_ff <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         resched_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         // pos wraps to 0 after each whole turn
         if (init_ff && csr_we) pos_ff <= '0;
         else if (rot_all) pos_ff <= pos_ff + 1'b1;
         if (init_ff && last && !csr_we) init_ff <= 1'b0;
         if (csr_we && state_ff == S_IDLE) prio_ff <= csr_wdata;
         else if (accept && req.payload.cmd == CMD_CREATE) prio_ff <= req.payload.new_priority;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff <= req.payload.cmd;
                  cur_ff <= run_ff;
                  before_ff <= run_ff;
                  status_ff <= 1'b0;
                  newt_ff <= '0;
                  resched_ff <= 1'b0;
                  state_ff <= S_CMD;
               end
            end
            S_CMD: begin
               if (resched_set) resched_ff <= 1'b1;
               if (last) begin
                  if (cmd_ff == CMD_CREATE) begin
                     if (taken_ff < CNT_W'(SLOTS)) begin
                        newt_ff <= taken_ff[SLOT_W-1:0];
                        taken_ff <= taken_ff + 1'b1;
                     end else begin
                        status_ff <= 1'b1;
                     end
                  end
                  found_ff <= 1'b0;
                  bestv_ff <= '0;
                  best_ff <= '0;
                  state_ff <= (resched_ff || resched_set) ? S_PICK : S_DONE;
               end
            end
            S_PICK, S_AGE: begin
               if (last && state_ff == S_PICK && pick_found &&
                   (better ? head_out.time_left : bestv_ff) == '0) begin
                  // every running counter is zero: age every used slot and scan again
                  found_ff <= 1'b0;
                  bestv_ff <= '0;
                  best_ff <= '0;
                  state_ff <= S_AGE;
               end else begin
                  if (better) begin
                     found_ff <= 1'b1;
                     bestv_ff <= head_out.time_left;
                     best_ff <= pos_ff;
                  end
                  if (last) begin
                     run_ff <= pick_found ? pick : '0;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_ff.current_task <= run_ff;
                  rsp_ff.switched <= (run_ff != before_ff);
                  rsp_ff.status <= status_ff;
                  rsp_ff.new_task <= newt_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/cpts_cell.sv -----
// One slot cell of the rotating slot ring.
// Depends on cpts_pkg.
module cpts_cell (
   input  logic clock,
   input  logic load,
   input  cpts_pkg::slot_type prev,
   output cpts_pkg::slot_type slot_ff
);
   import cpts_pkg::*;
   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= prev;
      end
   end
endmodule

// ----- rtl/cpts_head.sv -----
// Head stage of the ring: applies the pending operation to the slot passing by.
// Depends on cpts_pkg.
module cpts_head (
   input  cpts_pkg::op_type op,
   input  cpts_pkg::slot_type slot_in,
   input  logic [cpts_pkg::PRIO_W-1:0] prio,
   output cpts_pkg::slot_type slot_out
);
   import cpts_pkg::*;
   logic [TIME_W-1:0] aged;
   assign aged = TIME_W'(slot_in.time_left >> 1) + TIME_W'(slot_in.prio);
   always_comb begin
      slot_out = slot_in;
      case (op)
         OP_DEC: if (slot_in.time_left != '0) slot_out.time_left = slot_in.time_left - 1'b1;
         OP_ZERO: slot_out.time_left = '0;
         OP_KILL: begin
            slot_out.running = 1'b0;
            slot_out.time_left = '0;
         end
         OP_PUP: if (slot_in.depth != '1) slot_out.depth = slot_in.depth + 1'b1;
         OP_PDN: if (slot_in.depth != '0) slot_out.depth = slot_in.depth - 1'b1;
         OP_FILL: begin
            slot_out.used = 1'b1;
            slot_out.running = 1'b1;
            slot_out.prio = prio;
            slot_out.time_left = TIME_W'(prio);
            slot_out.depth = '0;
         end
         OP_AGE: if (slot_in.used) slot_out.time_left = aged;
         default: slot_out = slot_in;
      endcase
   end
endmodule
